// ----- sv/sfd_pkg.sv -----
// Shared types, constants and arithmetic helpers for the stereo feedback delay.
// Used by sfd_cfg, sfd_lane and stereo_feedback_delay; depends on nothing else.
package sfd_pkg;

  localparam int SMP_W     = 24;
  localparam int GAIN_W    = 16;
  localparam int DEPTH_DEF = 65536;
  localparam int UNITY     = 32768;
  localparam int RND_HALF  = 16384;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;

  localparam logic signed [27:0] SMP_MAX = 28'sd8388607;
  localparam logic signed [27:0] SMP_MIN = -28'sd8388608;

  typedef enum logic [1:0] {
    REG_DELAY    = 2'd0,
    REG_FEEDBACK = 2'd1,
    REG_WET      = 2'd2,
    REG_STEREO   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0] fb_gain;
    logic [GAIN_W-1:0] wet_mix;
    logic              stereo;
  } cfg_t;

  typedef struct packed {
    logic adv;   // whole pipeline moves on this edge
    logic acc;   // a request is taken on this edge
    logic proc;  // the request taken is processed by this lane
    logic clr;   // clearing pass in progress
  } lane_ctl_t;

  // Clamp to the signed 24-bit sample range.
  function automatic logic signed [SMP_W-1:0] sat24(input logic signed [27:0] x);
    logic signed [27:0] r;
    r = x;
    if (x > SMP_MAX) r = SMP_MAX;
    if (x < SMP_MIN) r = SMP_MIN;
    return r[SMP_W-1:0];
  endfunction

endpackage

// ----- sv/sfd_cfg.sv -----
// APB register file of the stereo feedback delay: raw registers for read-back
// and the clamped delay length. Depends on sfd_pkg.
module sfd_cfg import sfd_pkg::*; #(
  parameter  int DEPTH = DEPTH_DEF,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o,
  output logic [AW-1:0]     delay_o
);

  localparam int DW = (AW > 16) ? AW + 1 : 17;

  logic [GAIN_W-1:0] delay_q, fb_q, wet_q;
  logic              stereo_q;
  logic [AW-1:0]     eff_q, eff_d;
  logic              wr;
  logic [DW-1:0]     dly_w;
  reg_idx_e          idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = reg_idx_e'(paddr[3:2]);

  // Clamp delay to 1..DEPTH-1 at write time.
  always_comb begin
    dly_w = DW'(pwdata[GAIN_W-1:0]);
    eff_d = dly_w[AW-1:0];
    if (dly_w == '0) begin
      eff_d = AW'(1);
    end else if (dly_w > DW'(DEPTH - 1)) begin
      eff_d = AW'(DEPTH - 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q  <= GAIN_W'(1);
      fb_q     <= '0;
      wet_q    <= '0;
      stereo_q <= 1'b1;
      eff_q    <= AW'(1);
    end else if (wr) begin
      case (idx)
        REG_DELAY: begin
          delay_q <= pwdata[GAIN_W-1:0];
          eff_q   <= eff_d;
        end
        REG_FEEDBACK: fb_q     <= pwdata[GAIN_W-1:0];
        REG_WET:      wet_q    <= pwdata[GAIN_W-1:0];
        REG_STEREO:   stereo_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DELAY:    prdata = APB_DW'(delay_q);
      REG_FEEDBACK: prdata = APB_DW'(fb_q);
      REG_WET:      prdata = APB_DW'(wet_q);
      REG_STEREO:   prdata = APB_DW'(stereo_q);
      default:      prdata = '0;
    endcase
  end

  assign cfg_o   = '{fb_gain: fb_q, wet_mix: wet_q, stereo: stereo_q};
  assign delay_o = eff_q;

endmodule

// ----- sv/sfd_lane.sv -----
// One channel lane: circular delay store, write forwarding, feedback and
// dry/wet mix datapath over three stages. Depends on sfd_pkg.
module sfd_lane import sfd_pkg::*; #(
  parameter  int DEPTH = DEPTH_DEF,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lane_ctl_t               ctl_i,
  input  cfg_t                    cfg_i,
  input  logic [AW-1:0]           rd_addr_i,
  input  logic [AW-1:0]           wr_addr_i,
  input  logic [AW-1:0]           clr_addr_i,
  input  logic signed [SMP_W-1:0] in_i,
  output logic signed [SMP_W-1:0] y_o
);

  logic [SMP_W-1:0] mem [DEPTH];

  // stage 1
  logic signed [SMP_W-1:0] rdata_q, cap_d_q, in1_q, dly1;
  logic [AW-1:0]           rd1_q, wa1_q;
  logic                    cap_hit_q, proc1_q;
  // stage 2
  logic signed [SMP_W-1:0] dly2_q, in2_q, dl;
  logic [AW-1:0]           rd2_q, wa2_q;
  logic                    proc2_q, hit3;
  logic signed [16:0]      fb_s, wet_s;
  logic signed [17:0]      dry_s;
  logic signed [40:0]      p_fb, t_fb, p_wet;
  logic signed [41:0]      p_dry;
  logic signed [25:0]      fb_r;
  logic signed [26:0]      st_sum;
  logic signed [SMP_W-1:0] stored;
  // stage 3
  logic signed [SMP_W-1:0] st3_q, in3_q;
  logic [AW-1:0]           wa3_q;
  logic                    proc3_q;
  logic signed [41:0]      pdry3_q;
  logic signed [40:0]      pwet3_q;
  logic signed [42:0]      mix;
  // store port
  logic                    we;
  logic [AW-1:0]           wa;
  logic [SMP_W-1:0]        wd;

  // Take the write that landed on the read edge over the stale read data.
  assign dly1 = cap_hit_q ? cap_d_q : rdata_q;

  // Forward the sample that the item just ahead wrote after this item's store read.
  assign hit3 = proc3_q && (wa3_q == rd2_q);
  assign dl   = hit3 ? st3_q : dly2_q;

  assign fb_s   = $signed({1'b0, cfg_i.fb_gain});
  assign wet_s  = $signed({1'b0, cfg_i.wet_mix});
  assign dry_s  = 18'(UNITY) - 18'(wet_s);
  assign p_fb   = dl * fb_s;
  assign t_fb   = p_fb + 41'(RND_HALF);
  assign fb_r   = t_fb[40:15];
  assign st_sum = 27'(in2_q) + 27'(fb_r);
  assign stored = sat24(28'(st_sum));
  assign p_dry  = in2_q * dry_s;
  assign p_wet  = dl * wet_s;

  assign mix = 43'(pdry3_q) + 43'(pwet3_q) + 43'(RND_HALF);
  assign y_o = proc3_q ? sat24(mix[42:15]) : in3_q;

  assign we = ctl_i.clr || (ctl_i.adv && proc2_q);
  assign wa = ctl_i.clr ? clr_addr_i : wa2_q;
  assign wd = ctl_i.clr ? '0 : stored;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (ctl_i.adv) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_hit_q <= 1'b0;
      proc1_q   <= 1'b0;
      proc2_q   <= 1'b0;
      proc3_q   <= 1'b0;
    end else if (ctl_i.adv) begin
      cap_hit_q <= ctl_i.acc && ctl_i.proc && proc2_q && (wa2_q == rd_addr_i);
      proc1_q   <= ctl_i.acc && ctl_i.proc;
      proc2_q   <= proc1_q;
      proc3_q   <= proc2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      cap_d_q <= stored;
      in1_q   <= in_i;
      rd1_q   <= rd_addr_i;
      wa1_q   <= wr_addr_i;
      dly2_q  <= dly1;
      in2_q   <= in1_q;
      rd2_q   <= rd1_q;
      wa2_q   <= wa1_q;
      st3_q   <= stored;
      in3_q   <= in2_q;
      wa3_q   <= wa2_q;
      pdry3_q <= p_dry;
      pwet3_q <= p_wet;
    end
  end

endmodule

// ----- sv/stereo_feedback_delay.sv -----
// Top level of the stereo feedback delay: stream ports, write position,
// clearing pass, two channel lanes and the output register.
// Depends on sfd_pkg, sfd_cfg and sfd_lane.
//
// Usage:
//   Requests arrive on the s_axis group, one stereo pair per request; results
//   leave on the m_axis group, one stereo pair per request, in order.
//   Configuration goes through the APB port (delay, feedback, wet mix, stereo
//   mode at byte addresses 0, 4, 8, 12); write it only while no request is in
//   flight.
//   Pipeline: a request passes the store read, the feedback and mix
//   products, the final sum and saturation, then the output register.
//   Throughput: one request per cycle while the pipeline is not stalled
//   and no clearing pass runs. The feedback path - forwarding mux,
//   one 24x16 multiply, add and saturate - sets the clock limit, since a
//   delay of one sample feeds each result straight into the next request.
//   Reset: both delay stores are swept to zero, one entry per cycle, over
//   all DEPTH entries (65536 at the default); s_axis_tready stays low meanwhile,
//   APB writes are taken as usual.
//   Stall: when m_axis_tready is low with a result waiting, the whole
//   pipeline holds and s_axis_tready drops; one result sits in the output
//   register while the next requests stay in their stages.
module stereo_feedback_delay import sfd_pkg::*; #(
  parameter  int DEPTH = DEPTH_DEF,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // APB configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  // request stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [2*SMP_W-1:0]  s_axis_tdata,   // [23:0] left_in, [47:24] right_in
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [2*SMP_W-1:0]  m_axis_tdata    // [23:0] left_out, [47:24] right_out
);

  cfg_t          cfg;
  logic [AW-1:0] delay;

  logic          adv, acc, byp;
  logic [AW-1:0] wp_q, wp_d, rd_addr;
  logic [AW:0]   wp_x, dl_x;
  logic          clr_q;
  logic [AW-1:0] clr_addr_q;
  logic          vld1_q, vld2_q, vld3_q;
  logic          st1_q, st2_q, st3_q;
  logic          out_vld_q;
  logic [2*SMP_W-1:0] out_q;
  lane_ctl_t     ctl_l, ctl_r;
  logic signed [SMP_W-1:0] y_l, y_r;

  sfd_cfg #(.DEPTH(DEPTH)) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .delay_o (delay)
  );

  // Advance whenever the output register is free or being emptied.
  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv && !clr_q;
  assign acc           = s_axis_tvalid && s_axis_tready;
  // Zero wet mix bypasses the effect: no store write, no position advance.
  assign byp           = (cfg.wet_mix == '0);

  // Read index is the write position minus the delay, modulo DEPTH.
  assign wp_x    = (AW+1)'(wp_q);
  assign dl_x    = (AW+1)'(delay);
  always_comb begin
    if (wp_x >= dl_x) begin
      rd_addr = AW'(wp_x - dl_x);
    end else begin
      rd_addr = AW'(wp_x + (AW+1)'(DEPTH) - dl_x);
    end
  end

  assign wp_d = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);

  assign ctl_l = '{adv: adv, acc: acc, proc: !byp, clr: clr_q};
  assign ctl_r = '{adv: adv, acc: acc, proc: !byp && cfg.stereo, clr: clr_q};

  sfd_lane #(.DEPTH(DEPTH)) u_lane_l (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl_l),
    .cfg_i      (cfg),
    .rd_addr_i  (rd_addr),
    .wr_addr_i  (wp_q),
    .clr_addr_i (clr_addr_q),
    .in_i       ($signed(s_axis_tdata[SMP_W-1:0])),
    .y_o        (y_l)
  );

  sfd_lane #(.DEPTH(DEPTH)) u_lane_r (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl_r),
    .cfg_i      (cfg),
    .rd_addr_i  (rd_addr),
    .wr_addr_i  (wp_q),
    .clr_addr_i (clr_addr_q),
    .in_i       ($signed(s_axis_tdata[2*SMP_W-1:SMP_W])),
    .y_o        (y_r)
  );

  // Write position and clearing sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      if (acc && !byp) begin
        wp_q <= wp_d;
      end
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(DEPTH - 1)) begin
          clr_q <= 1'b0;
        end
      end
    end
  end

  // Stage valids, stereo flag per request, and the merging output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q    <= 1'b0;
      vld2_q    <= 1'b0;
      vld3_q    <= 1'b0;
      st1_q     <= 1'b0;
      st2_q     <= 1'b0;
      st3_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld1_q    <= acc;
      vld2_q    <= vld1_q;
      vld3_q    <= vld2_q;
      st1_q     <= cfg.stereo;
      st2_q     <= st1_q;
      st3_q     <= st2_q;
      out_vld_q <= vld3_q;
    end
  end

  // Drop the right channel in mono mode.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= {(st3_q ? y_r : SMP_W'(0)), y_l};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  // The sweep runs with the pipeline empty, so no item write can collide.
  a_clr_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !(vld1_q || vld2_q || vld3_q))
    else $error("request in flight during clearing pass");

  a_wp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= AW'(DEPTH - 1))
    else $error("write position beyond store depth");

  a_byp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && byp) |=> $stable(wp_q))
    else $error("write position moved on a bypassed request");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && vld3_q) |=> m_axis_tvalid)
    else $error("result lost between final stage and output register");

endmodule
